// ===== design/particle_physics_update_assert.svh =====
// ----------------------------------------------------------------------------
// Particle physics update assertion macros
// Concurrent check wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_PHYSICS_UPDATE_ASSERT_SVH
`define PARTICLE_PHYSICS_UPDATE_ASSERT_SVH
`ifndef SYNTH
`define PPU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("particle_physics_update: check failed");
`define PPU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("particle_physics_update: check failed");
`else
`define PPU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PPU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle physics update package
// Shared types, register indexes, fixed-point limits and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none
package ppu_pkg;

	localparam int VAL_W  = 21;
	localparam int RAMP_W = 12;
	localparam int FT_W   = 16;
	localparam int GRAV_W = 12;
	localparam int TIME_W = 31;
	localparam int EXP_W  = 32;
	localparam int SUM_W  = 27;

	localparam logic [1:0] REG_FRAME_TIME   = 2'd0;
	localparam logic [1:0] REG_GRAVITY      = 2'd1;
	localparam logic [1:0] REG_CURRENT_TIME = 2'd2;

	localparam logic [GRAV_W-1:0] GRAVITY_RESET = 12'd800;
	localparam logic [RAMP_W-1:0] RAMP_MAX      = 12'd4095;
	localparam logic [RAMP_W-1:0] FIRE_LIMIT    = 12'd1536;
	localparam logic [RAMP_W-1:0] EXPLODE_LIMIT = 12'd2048;
	// floor(x / 5) = (x * GRAV_RECIP) >> 20 for x below 2^18
	localparam logic [17:0] GRAV_RECIP  = 18'd209716;
	// floor(y / 3) = (y * ALPHA_RECIP) >> 11 for y below 2^11
	localparam logic [9:0]  ALPHA_RECIP = 10'd683;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef enum logic [2:0] {
		KIND_STATIC,
		KIND_FIRE,
		KIND_EXPLODE,
		KIND_EXPLODE2,
		KIND_BLOB,
		KIND_BLOB2,
		KIND_GRAV,
		KIND_SLOWGRAV
	} kind_t;

	typedef enum logic [1:0] {
		VOP_KEEP,
		VOP_ADD_DECAY,
		VOP_SUB_DECAY,
		VOP_SUB_FRAME
	} vop_t;

	typedef enum logic [1:0] {
		GOP_NONE,
		GOP_ADD,
		GOP_SUB
	} gop_t;

	typedef enum logic [1:0] {
		SEL_KEEP,
		SEL_FIRE,
		SEL_EXPLODE,
		SEL_EXPLODE2
	} sel_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
	} ctl_t;

	typedef struct packed {
		logic [FT_W-1:0]   frame_time;
		logic [GRAV_W-1:0] gravity;
		logic [TIME_W-1:0] current_time;
	} cfg_t;

	function automatic val_t sat_val(input logic signed [SUM_W-1:0] v);
		val_t r;
		if (v > 27'sd1048575) begin
			r = 21'sd1048575;
		end else if (v < -27'sd1048576) begin
			r = -21'sd1048576;
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/particle_physics_update.sv =====
// ----------------------------------------------------------------------------
// Particle physics update
// One Euler step per particle record: expiry, motion, drag, gravity, ramp.
// ----------------------------------------------------------------------------
// Takes one particle record per cycle while in_ready is high and returns its
// updated record through a four-stage pipeline (input register, multiply,
// accumulate, gravity and saturation with the output register). Every stage
// holds its own valid bit and fills bubbles while the output is stalled, so
// in_ready drops only when all four stages hold an item. Configuration is
// taken on every write and has no clearing pass after reset.
`default_nettype none
`include "particle_physics_update_assert.svh"
module particle_physics_update (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [30:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          particle_kind,
	input  logic signed [20:0]  pos_x,
	input  logic signed [20:0]  pos_y,
	input  logic signed [20:0]  pos_z,
	input  logic signed [20:0]  vel_x,
	input  logic signed [20:0]  vel_y,
	input  logic signed [20:0]  vel_z,
	input  logic [11:0]         ramp_in,
	input  logic signed [31:0]  expiry_time,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                dropped,
	output logic signed [20:0]  new_pos_x,
	output logic signed [20:0]  new_pos_y,
	output logic signed [20:0]  new_pos_z,
	output logic signed [20:0]  new_vel_x,
	output logic signed [20:0]  new_vel_y,
	output logic signed [20:0]  new_vel_z,
	output logic [11:0]         new_ramp,
	output logic [1:0]          ramp_table_sel,
	output logic [2:0]          ramp_index,
	output logic                retired,
	output logic [7:0]          alpha
);

	ppu_pkg::cfg_t  cfg;
	ppu_pkg::ctl_t  ctl;
	ppu_pkg::kind_t kind;
	ppu_pkg::vop_t  vop_xy, vop_z;
	ppu_pkg::gop_t  gop_z;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic drop_in, drop_s1, drop_s2, drop_s3, drop_s4;
	logic [27:0] gp_s1;
	logic [35:0] gx_s2;
	logic [15:0] grav_s3;

	ppu_pkg::val_t lp_x, lp_y, lp_z, lv_x, lv_y, lv_z;
	logic [11:0] l_ramp;
	logic [1:0]  l_sel;
	logic [2:0]  l_idx;
	logic        l_ret;
	logic [7:0]  l_alpha;

	ppu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stall chain: a stage loads when empty or when its successor moves
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign ctl.en1 = rdy1 && in_valid;
	assign ctl.en2 = rdy2 && v_s1;
	assign ctl.en3 = rdy3 && v_s2;
	assign ctl.en4 = rdy4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign kind    = ppu_pkg::kind_t'(particle_kind);
	assign drop_in = $signed({expiry_time[31], expiry_time})
		< $signed({2'b00, cfg.current_time});

	always_comb begin
		vop_xy = ppu_pkg::VOP_KEEP;
		vop_z  = ppu_pkg::VOP_KEEP;
		gop_z  = ppu_pkg::GOP_SUB;
		case (kind)
			ppu_pkg::KIND_STATIC: begin
				gop_z = ppu_pkg::GOP_NONE;
			end
			ppu_pkg::KIND_FIRE: begin
				gop_z = ppu_pkg::GOP_ADD;
			end
			ppu_pkg::KIND_EXPLODE, ppu_pkg::KIND_BLOB: begin
				vop_xy = ppu_pkg::VOP_ADD_DECAY;
				vop_z  = ppu_pkg::VOP_ADD_DECAY;
			end
			ppu_pkg::KIND_EXPLODE2: begin
				vop_xy = ppu_pkg::VOP_SUB_FRAME;
				vop_z  = ppu_pkg::VOP_SUB_FRAME;
			end
			ppu_pkg::KIND_BLOB2: begin
				vop_xy = ppu_pkg::VOP_SUB_DECAY;
			end
			default: begin
			end
		endcase
	end

	// gravity step: floor(frame_time * gravity / 5120)
	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			drop_s1 <= drop_in;
			gp_s1   <= 28'(cfg.frame_time) * 28'(cfg.gravity);
		end
		if (ctl.en2) begin
			drop_s2 <= drop_s1;
			gx_s2   <= 36'(gp_s1[27:10]) * 36'(ppu_pkg::GRAV_RECIP);
		end
		if (ctl.en3) begin
			drop_s3 <= drop_s2;
			grav_s3 <= gx_s2[35:20];
		end
		if (ctl.en4) begin
			drop_s4 <= drop_s3;
		end
	end

	ppu_axis u_axis_x (
		.clk        (clk),
		.ctl        (ctl),
		.frame_time (cfg.frame_time),
		.pos        (pos_x),
		.vel        (vel_x),
		.vop        (vop_xy),
		.gop        (ppu_pkg::GOP_NONE),
		.grav       (grav_s3),
		.new_pos    (lp_x),
		.new_vel    (lv_x)
	);

	ppu_axis u_axis_y (
		.clk        (clk),
		.ctl        (ctl),
		.frame_time (cfg.frame_time),
		.pos        (pos_y),
		.vel        (vel_y),
		.vop        (vop_xy),
		.gop        (ppu_pkg::GOP_NONE),
		.grav       (grav_s3),
		.new_pos    (lp_y),
		.new_vel    (lv_y)
	);

	ppu_axis u_axis_z (
		.clk        (clk),
		.ctl        (ctl),
		.frame_time (cfg.frame_time),
		.pos        (pos_z),
		.vel        (vel_z),
		.vop        (vop_z),
		.gop        (gop_z),
		.grav       (grav_s3),
		.new_pos    (lp_z),
		.new_vel    (lv_z)
	);

	ppu_ramp u_ramp (
		.clk            (clk),
		.ctl            (ctl),
		.frame_time     (cfg.frame_time),
		.ramp_in        (ramp_in),
		.kind           (kind),
		.new_ramp       (l_ramp),
		.ramp_table_sel (l_sel),
		.ramp_index     (l_idx),
		.retired        (l_ret),
		.alpha          (l_alpha)
	);

	// drop: clear every field but the flag
	assign out_valid      = v_s4;
	assign dropped        = drop_s4;
	assign new_pos_x      = drop_s4 ? '0 : lp_x;
	assign new_pos_y      = drop_s4 ? '0 : lp_y;
	assign new_pos_z      = drop_s4 ? '0 : lp_z;
	assign new_vel_x      = drop_s4 ? '0 : lv_x;
	assign new_vel_y      = drop_s4 ? '0 : lv_y;
	assign new_vel_z      = drop_s4 ? '0 : lv_z;
	assign new_ramp       = drop_s4 ? '0 : l_ramp;
	assign ramp_table_sel = drop_s4 ? '0 : l_sel;
	assign ramp_index     = drop_s4 ? '0 : l_idx;
	assign retired        = drop_s4 ? 1'b0 : l_ret;
	assign alpha          = drop_s4 ? '0 : l_alpha;

	`PPU_ASSERT_IMP(a_full_on_stall, clk, arst_n, !in_ready, v_s1 && v_s2 && v_s3 && v_s4)
	`PPU_ASSERT_NXT(a_s1_holds, clk, arst_n, v_s1 && !rdy2, v_s1)
	`PPU_ASSERT_IMP(a_retire_keeps, clk, arst_n, out_valid && retired, ramp_table_sel == ppu_pkg::SEL_KEEP && ramp_index == 3'd0)
	`PPU_ASSERT_IMP(a_fire_below, clk, arst_n, out_valid && ramp_table_sel == ppu_pkg::SEL_FIRE, new_ramp < ppu_pkg::FIRE_LIMIT)

endmodule
`default_nettype wire

// ===== design/ppu_cfg.sv =====
// ----------------------------------------------------------------------------
// Particle physics update configuration registers
// Frame time, gravity and current time, written over the config channel.
// ----------------------------------------------------------------------------
`default_nettype none
module ppu_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [ppu_pkg::TIME_W-1:0]  cfg_data,
	output ppu_pkg::cfg_t               cfg
);

	ppu_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_time   <= '0;
			cfg_q.gravity      <= ppu_pkg::GRAVITY_RESET;
			cfg_q.current_time <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ppu_pkg::REG_FRAME_TIME: begin
					cfg_q.frame_time <= cfg_data[ppu_pkg::FT_W-1:0];
				end
				ppu_pkg::REG_GRAVITY: begin
					cfg_q.gravity <= cfg_data[ppu_pkg::GRAV_W-1:0];
				end
				ppu_pkg::REG_CURRENT_TIME: begin
					cfg_q.current_time <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/ppu_axis.sv =====
// ----------------------------------------------------------------------------
// Particle physics update axis lane
// Four-stage position and velocity update for one coordinate axis.
// ----------------------------------------------------------------------------
`default_nettype none
module ppu_axis (
	input  logic                      clk,
	input  ppu_pkg::ctl_t             ctl,
	input  logic [ppu_pkg::FT_W-1:0]  frame_time,
	input  ppu_pkg::val_t             pos,
	input  ppu_pkg::val_t             vel,
	input  ppu_pkg::vop_t             vop,
	input  ppu_pkg::gop_t             gop,
	input  logic [15:0]               grav,
	output ppu_pkg::val_t             new_pos,
	output ppu_pkg::val_t             new_vel
);

	ppu_pkg::val_t pos_s1, vel_s1, pos_s2, vel_s2, pos_s3;
	ppu_pkg::vop_t vop_s1, vop_s2;
	ppu_pkg::gop_t gop_s1, gop_s2, gop_s3;
	logic signed [37:0] prod_s2;
	logic signed [ppu_pkg::SUM_W-1:0] velm_s3;
	ppu_pkg::val_t new_pos_s4, new_vel_s4;

	logic signed [ppu_pkg::SUM_W-1:0] step16, step14, pos_sum, velm, vfull, gext;

	always_comb begin
		step16  = ppu_pkg::SUM_W'($signed(prod_s2[37:16]));
		step14  = ppu_pkg::SUM_W'($signed(prod_s2[37:14]));
		pos_sum = ppu_pkg::SUM_W'(pos_s2) + step16;
		case (vop_s2)
			ppu_pkg::VOP_ADD_DECAY: velm = ppu_pkg::SUM_W'(vel_s2) + step14;
			ppu_pkg::VOP_SUB_DECAY: velm = ppu_pkg::SUM_W'(vel_s2) - step14;
			ppu_pkg::VOP_SUB_FRAME: velm = ppu_pkg::SUM_W'(vel_s2) - step16;
			default:                velm = ppu_pkg::SUM_W'(vel_s2);
		endcase
	end

	always_comb begin
		gext = $signed(ppu_pkg::SUM_W'(grav));
		case (gop_s3)
			ppu_pkg::GOP_ADD: vfull = velm_s3 + gext;
			ppu_pkg::GOP_SUB: vfull = velm_s3 - gext;
			default:          vfull = velm_s3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			pos_s1 <= pos;
			vel_s1 <= vel;
			vop_s1 <= vop;
			gop_s1 <= gop;
		end
		if (ctl.en2) begin
			prod_s2 <= 38'(vel_s1) * 38'($signed({1'b0, frame_time}));
			pos_s2  <= pos_s1;
			vel_s2  <= vel_s1;
			vop_s2  <= vop_s1;
			gop_s2  <= gop_s1;
		end
		if (ctl.en3) begin
			pos_s3  <= ppu_pkg::sat_val(pos_sum);
			velm_s3 <= velm;
			gop_s3  <= gop_s2;
		end
		if (ctl.en4) begin
			new_pos_s4 <= pos_s3;
			new_vel_s4 <= ppu_pkg::sat_val(vfull);
		end
	end

	assign new_pos = new_pos_s4;
	assign new_vel = new_vel_s4;

endmodule
`default_nettype wire

// ===== design/ppu_ramp.sv =====
// ----------------------------------------------------------------------------
// Particle physics update ramp lane
// Four-stage color ramp advance, retirement, table select and fire alpha.
// ----------------------------------------------------------------------------
`default_nettype none
module ppu_ramp (
	input  logic                        clk,
	input  ppu_pkg::ctl_t               ctl,
	input  logic [ppu_pkg::FT_W-1:0]    frame_time,
	input  logic [ppu_pkg::RAMP_W-1:0]  ramp_in,
	input  ppu_pkg::kind_t              kind,
	output logic [ppu_pkg::RAMP_W-1:0]  new_ramp,
	output logic [1:0]                  ramp_table_sel,
	output logic [2:0]                  ramp_index,
	output logic                        retired,
	output logic [7:0]                  alpha
);

	logic [ppu_pkg::RAMP_W-1:0] ramp_s1, nramp_s3, new_ramp_s4;
	ppu_pkg::kind_t kind_s1, kind_s2, kind_s3;
	logic [ppu_pkg::RAMP_W:0] rsum_s2;
	logic [9:0] ay_s2;
	logic fire_s2, live_s2;
	logic [7:0] alpha_s3, alpha_s4;
	ppu_pkg::sel_t sel_s4;
	logic [2:0] idx_s4;
	logic ret_s4;

	logic [3:0]  mult;
	logic [19:0] rprod;
	logic [ppu_pkg::RAMP_W-1:0] fdiff;
	logic [18:0] aprod;
	logic [19:0] qprod;
	logic [ppu_pkg::RAMP_W-1:0] limit;
	logic has_ramp;

	always_comb begin
		case (kind_s1)
			ppu_pkg::KIND_FIRE:     mult = 4'd5;
			ppu_pkg::KIND_EXPLODE:  mult = 4'd10;
			ppu_pkg::KIND_EXPLODE2: mult = 4'd15;
			default:                mult = 4'd0;
		endcase
		rprod = 20'(frame_time) * 20'(mult);
		fdiff = ppu_pkg::FIRE_LIMIT - ramp_s1;
		aprod = 19'(8'd255) * 19'(fdiff[10:0]);
	end

	always_comb begin
		qprod = 20'(ay_s2) * 20'(ppu_pkg::ALPHA_RECIP);
	end

	always_comb begin
		has_ramp = 1'b1;
		limit    = ppu_pkg::EXPLODE_LIMIT;
		case (kind_s3)
			ppu_pkg::KIND_FIRE:     limit = ppu_pkg::FIRE_LIMIT;
			ppu_pkg::KIND_EXPLODE:  limit = ppu_pkg::EXPLODE_LIMIT;
			ppu_pkg::KIND_EXPLODE2: limit = ppu_pkg::EXPLODE_LIMIT;
			default:                has_ramp = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			ramp_s1 <= ramp_in;
			kind_s1 <= kind;
		end
		if (ctl.en2) begin
			rsum_s2 <= 13'(ramp_s1) + 13'(rprod[19:8]);
			ay_s2   <= aprod[18:9];
			fire_s2 <= (kind_s1 == ppu_pkg::KIND_FIRE);
			live_s2 <= (ramp_s1 < ppu_pkg::FIRE_LIMIT);
			kind_s2 <= kind_s1;
		end
		if (ctl.en3) begin
			nramp_s3 <= rsum_s2[ppu_pkg::RAMP_W] ? ppu_pkg::RAMP_MAX
				: rsum_s2[ppu_pkg::RAMP_W-1:0];
			if (!fire_s2) begin
				alpha_s3 <= 8'd255;
			end else if (live_s2) begin
				alpha_s3 <= qprod[18:11];
			end else begin
				alpha_s3 <= 8'd0;
			end
			kind_s3 <= kind_s2;
		end
		if (ctl.en4) begin
			new_ramp_s4 <= nramp_s3;
			alpha_s4    <= alpha_s3;
			if (has_ramp && nramp_s3 >= limit) begin
				ret_s4 <= 1'b1;
				sel_s4 <= ppu_pkg::SEL_KEEP;
				idx_s4 <= 3'd0;
			end else if (has_ramp) begin
				ret_s4 <= 1'b0;
				sel_s4 <= ppu_pkg::sel_t'(kind_s3[1:0]);
				idx_s4 <= nramp_s3[10:8];
			end else begin
				ret_s4 <= 1'b0;
				sel_s4 <= ppu_pkg::SEL_KEEP;
				idx_s4 <= 3'd0;
			end
		end
	end

	assign new_ramp       = new_ramp_s4;
	assign ramp_table_sel = sel_s4;
	assign ramp_index     = idx_s4;
	assign retired        = ret_s4;
	assign alpha          = alpha_s4;

endmodule
`default_nettype wire

// ===== bench/ppu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle update scoreboard
// Watches the register, record and result channels of the particle update
// block, predicts each updated record from its own copy of the frame
// registers and compares every returned record field by field, in order.
// ----------------------------------------------------------------------------
module ppu_checker
	import ppu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         particle_kind,
	input  logic signed [20:0] pos_x,
	input  logic signed [20:0] pos_y,
	input  logic signed [20:0] pos_z,
	input  logic signed [20:0] vel_x,
	input  logic signed [20:0] vel_y,
	input  logic signed [20:0] vel_z,
	input  logic [11:0]        ramp_in,
	input  logic signed [31:0] expiry_time,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               dropped,
	input  logic signed [20:0] new_pos_x,
	input  logic signed [20:0] new_pos_y,
	input  logic signed [20:0] new_pos_z,
	input  logic signed [20:0] new_vel_x,
	input  logic signed [20:0] new_vel_y,
	input  logic signed [20:0] new_vel_z,
	input  logic [11:0]        new_ramp,
	input  logic [1:0]         ramp_table_sel,
	input  logic [2:0]         ramp_index,
	input  logic               retired,
	input  logic [7:0]         alpha,
	output int                 fail_count,
	output int                 outstanding,
	output int                 checked
);

	localparam longint COORD_HI    = 1048575;
	localparam longint COORD_LO    = -1048576;
	localparam longint RAMP_TOP    = 4095;
	localparam longint FIRE_END    = 1536;
	localparam longint EXPLODE_END = 2048;

	typedef struct {
		bit             dropped;
		val_t           npos [3];
		val_t           nvel [3];
		logic [11:0]    nramp;
		sel_t           sel;
		logic [2:0]     idx;
		bit             retired;
		logic [7:0]     alpha;
	} particle_update_t;

	particle_update_t updates_due [$];
	logic [15:0] frame_q;
	logic [11:0] gravity_q;
	logic [30:0] now_q;
	int errors;
	int n_checked;

	initial begin
		errors = 0;
		n_checked = 0;
	end

	function automatic val_t clip_coord(input longint v);
		if (v > COORD_HI)
			return val_t'(COORD_HI);
		if (v < COORD_LO)
			return val_t'(COORD_LO);
		return val_t'(v);
	endfunction

	function automatic particle_update_t euler_step(input kind_t kind, input val_t p [3],
			input val_t v [3], input logic [11:0] ramp, input logic signed [31:0] expiry);
		particle_update_t r;
		longint ft;
		longint g;
		longint dv;
		longint nv [3];
		longint nr;
		ft = longint'(frame_q);
		g = (ft * longint'(gravity_q)) / 5120;
		dv = ft * 4;
		r.dropped = 0;
		r.nramp = '0;
		r.sel = SEL_KEEP;
		r.idx = '0;
		r.retired = 0;
		r.alpha = '0;
		for (int i = 0; i < 3; i++) begin
			r.npos[i] = '0;
			r.nvel[i] = '0;
		end
		if (longint'(expiry) < longint'(now_q)) begin
			r.dropped = 1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			r.npos[i] = clip_coord(longint'(p[i]) + ((longint'(v[i]) * ft) >>> 16));
			nv[i] = longint'(v[i]);
		end
		r.alpha = 8'd255;
		if (kind == KIND_FIRE)
			r.alpha = (longint'(ramp) >= FIRE_END) ? 8'd0 :
				8'((255 * (FIRE_END - longint'(ramp))) / FIRE_END);
		nr = longint'(ramp);
		case (kind)
			KIND_FIRE: begin
				nr = nr + ((ft * 5) >>> 8);
				nv[2] = nv[2] + g;
			end
			KIND_EXPLODE, KIND_BLOB: begin
				if (kind == KIND_EXPLODE)
					nr = nr + ((ft * 10) >>> 8);
				for (int i = 0; i < 3; i++)
					nv[i] = nv[i] + ((nv[i] * dv) >>> 16);
				nv[2] = nv[2] - g;
			end
			KIND_EXPLODE2: begin
				nr = nr + ((ft * 15) >>> 8);
				for (int i = 0; i < 3; i++)
					nv[i] = nv[i] - ((nv[i] * ft) >>> 16);
				nv[2] = nv[2] - g;
			end
			KIND_BLOB2: begin
				for (int i = 0; i < 2; i++)
					nv[i] = nv[i] - ((nv[i] * dv) >>> 16);
				nv[2] = nv[2] - g;
			end
			KIND_GRAV, KIND_SLOWGRAV: begin
				nv[2] = nv[2] - g;
			end
			default: begin
			end
		endcase
		if (nr > RAMP_TOP)
			nr = RAMP_TOP;
		r.nramp = 12'(nr);
		if (kind == KIND_FIRE || kind == KIND_EXPLODE || kind == KIND_EXPLODE2) begin
			if (nr >= ((kind == KIND_FIRE) ? FIRE_END : EXPLODE_END)) begin
				r.retired = 1;
			end else begin
				case (kind)
					KIND_FIRE:    r.sel = SEL_FIRE;
					KIND_EXPLODE: r.sel = SEL_EXPLODE;
					default:      r.sel = SEL_EXPLODE2;
				endcase
				r.idx = 3'((nr >>> 8) & 7);
			end
		end
		for (int i = 0; i < 3; i++)
			r.nvel[i] = clip_coord(nv[i]);
		return r;
	endfunction

	task automatic check_field(input string what, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		val_t p_in [3];
		val_t v_in [3];
		particle_update_t want;
		if (!arst_n) begin
			frame_q = '0;
			gravity_q = 12'd800;
			now_q = '0;
			updates_due.delete();
			outstanding <= 0;
			fail_count <= errors;
			checked <= n_checked;
		end else begin
			if (out_valid && out_ready) begin
				if (updates_due.size() == 0) begin
					$display("%0t: result transfer with no record pending, expected none, got dropped=%0d",
						$time, dropped);
					errors++;
				end else begin
					want = updates_due.pop_front();
					n_checked++;
					check_field("dropped", want.dropped, dropped);
					check_field("new_pos_x", want.npos[0], new_pos_x);
					check_field("new_pos_y", want.npos[1], new_pos_y);
					check_field("new_pos_z", want.npos[2], new_pos_z);
					check_field("new_vel_x", want.nvel[0], new_vel_x);
					check_field("new_vel_y", want.nvel[1], new_vel_y);
					check_field("new_vel_z", want.nvel[2], new_vel_z);
					check_field("new_ramp", want.nramp, new_ramp);
					check_field("ramp_table_sel", want.sel, ramp_table_sel);
					check_field("ramp_index", want.idx, ramp_index);
					check_field("retired", want.retired, retired);
					check_field("alpha", want.alpha, alpha);
				end
			end
			if (in_valid && in_ready) begin
				p_in = '{pos_x, pos_y, pos_z};
				v_in = '{vel_x, vel_y, vel_z};
				updates_due.push_back(euler_step(kind_t'(particle_kind), p_in, v_in, ramp_in,
					expiry_time));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_TIME:   frame_q = cfg_data[15:0];
					REG_GRAVITY:      gravity_q = cfg_data[11:0];
					REG_CURRENT_TIME: now_q = cfg_data;
					default: begin
					end
				endcase
			end
			outstanding <= updates_due.size();
			fail_count <= errors;
			checked <= n_checked;
		end
	end

endmodule

// ===== bench/tb_particle_physics_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle physics update testbench
// Drives directed edge cases and randomized particle records through the
// update block under several frame settings, with random gaps and output
// stalls, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module tb_particle_physics_update;
	import ppu_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam val_t V_HI = 21'sd1048575;
	localparam val_t V_LO = -21'sd1048576;
	localparam logic signed [31:0] EXP_HI = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] EXP_LO = 32'sh8000_0000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 200;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [30:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         particle_kind;
	logic signed [20:0] pos_x;
	logic signed [20:0] pos_y;
	logic signed [20:0] pos_z;
	logic signed [20:0] vel_x;
	logic signed [20:0] vel_y;
	logic signed [20:0] vel_z;
	logic [11:0]        ramp_in;
	logic signed [31:0] expiry_time;
	logic               out_valid;
	logic               out_ready;
	logic               dropped;
	logic signed [20:0] new_pos_x;
	logic signed [20:0] new_pos_y;
	logic signed [20:0] new_pos_z;
	logic signed [20:0] new_vel_x;
	logic signed [20:0] new_vel_y;
	logic signed [20:0] new_vel_z;
	logic [11:0]        new_ramp;
	logic [1:0]         ramp_table_sel;
	logic [2:0]         ramp_index;
	logic               retired;
	logic [7:0]         alpha;
	int                 fail_count;
	int                 outstanding;
	int                 checked;

	int     send_gap_max;
	int     recv_stall_max;
	int     items_sent;
	longint frame_now;

	particle_physics_update u_dut (.*);

	ppu_checker u_checker (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, recv_stall_max);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic set_frame(input logic [15:0] ft, input logic [11:0] g, input logic [30:0] ct);
		logic [1:0] idx [4];
		logic [30:0] val [4];
		idx = '{REG_FRAME_TIME, REG_GRAVITY, REG_CURRENT_TIME, REG_UNUSED};
		val = '{31'(ft), 31'(g), ct, 31'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		frame_now = longint'(ct);
	endtask

	task automatic send_particle(input logic [2:0] k, input val_t px, input val_t py,
			input val_t pz, input val_t vx, input val_t vy, input val_t vz,
			input logic [11:0] r, input logic signed [31:0] e);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		particle_kind <= k;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		vel_x <= vx;
		vel_y <= vy;
		vel_z <= vz;
		ramp_in <= r;
		expiry_time <= e;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// hold off until every pending record has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic val_t rand_coord();
		case ($urandom_range(0, 5))
			0: return val_t'($urandom);
			1: return $urandom_range(0, 1) ? V_HI : V_LO;
			default: return val_t'(int'($urandom_range(0, 16383)) - 8192);
		endcase
	endfunction

	task automatic random_particle();
		longint e;
		case ($urandom_range(0, 7))
			0: e = longint'(int'($urandom));
			1: e = frame_now - 1 - longint'($urandom_range(0, 65535));
			default: begin
				e = frame_now + longint'($urandom_range(0, 1 << 20));
				if (e > longint'(EXP_HI))
					e = longint'(EXP_HI);
			end
		endcase
		send_particle(3'($urandom_range(0, 7)), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(),
			$urandom_range(0, 1) ? 12'($urandom_range(0, 2047)) : 12'($urandom_range(0, 4095)),
			32'(e));
	endtask

	initial begin
		logic [15:0] ft;
		logic [11:0] g;
		logic [30:0] ct;
		items_sent = 0;
		send_gap_max = 3;
		recv_stall_max = 3;
		frame_now = 0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		particle_kind <= '0;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		vel_x <= '0;
		vel_y <= '0;
		vel_z <= '0;
		ramp_in <= '0;
		expiry_time <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// longest frame, strongest gravity, one second in
		set_frame(16'hFFFF, 12'd4095, 31'h0001_0000);
		send_particle(KIND_STATIC, 0, 0, 0, 0, 0, 0, 12'd0, 32'sh0001_0000);
		send_particle(KIND_STATIC, V_HI, V_LO, V_HI, V_LO, V_HI, V_LO, 12'd4095, 32'sh0000_FFFF);
		send_particle(KIND_GRAV, 100, 200, 300, 5, 6, 7, 12'd100, EXP_LO);
		send_particle(KIND_FIRE, V_HI, V_HI, V_HI, V_HI, V_HI, V_HI, 12'd0, EXP_HI);
		send_particle(KIND_FIRE, V_LO, V_LO, V_LO, V_LO, V_LO, V_LO, 12'd4095, EXP_HI);
		send_particle(KIND_EXPLODE, 0, 0, 0, V_LO, V_LO, V_LO, 12'd0, EXP_HI);
		send_particle(KIND_EXPLODE2, 0, 0, 0, V_HI, V_HI, V_HI, 12'd4095, EXP_HI);
		send_particle(KIND_BLOB, -1, -1, -1, -1, -1, -1, 12'd256, EXP_HI);
		send_particle(KIND_BLOB2, 1000, -1000, 0, V_HI, V_LO, V_HI, 12'd512, EXP_HI);
		send_particle(KIND_GRAV, 0, 0, V_LO, 0, 0, V_LO, 12'd0, EXP_HI);
		send_particle(KIND_SLOWGRAV, 0, 0, 0, 0, 0, 0, 12'd7, EXP_HI);
		send_particle(KIND_FIRE, 0, 0, 0, 0, 0, V_HI, 12'd1535, EXP_HI);
		drain();

		// short frame so ramps cross their limits in steps of one to three
		set_frame(16'd64, 12'd800, 31'd0);
		send_particle(KIND_FIRE, 10, 20, 30, 40, 50, 60, 12'd1535, 32'sd100);
		send_particle(KIND_FIRE, 10, 20, 30, 40, 50, 60, 12'd1534, 32'sd100);
		send_particle(KIND_FIRE, 0, 0, 0, 0, 0, 0, 12'd1536, 32'sd100);
		send_particle(KIND_EXPLODE, -5, -6, -7, -300, 300, -300, 12'd2046, 32'sd100);
		send_particle(KIND_EXPLODE, -5, -6, -7, -300, 300, -300, 12'd2045, 32'sd100);
		send_particle(KIND_EXPLODE2, 5, 6, 7, 300, -300, 300, 12'd1023, 32'sd100);
		send_particle(KIND_BLOB2, 5, 6, 7, -4096, 4096, -4096, 12'd0, 32'sd100);
		send_particle(KIND_GRAV, 0, 0, 0, 0, 0, 0, 12'd0, 32'sd0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					ft = '0;
					g = '0;
					ct = '0;
				end
				1: begin
					ft = 16'hFFFF;
					g = 12'hFFF;
					ct = 31'h7FFF_FFFF;
				end
				2: begin
					ft = 16'd1092;
					g = 12'd800;
					ct = 31'($urandom);
				end
				default: begin
					ft = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4096));
					g = 12'($urandom);
					ct = 31'($urandom);
				end
			endcase
			set_frame(ft, g, ct);
			send_gap_max = (p % 4 == 1 || p == 5) ? 0 : 15;
			recv_stall_max = (p % 4 == 1) ? 0 : 15;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 3 && n == PHASE_ITEMS / 2)
					drain();
				random_particle();
			end
			drain();
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d particle records under %0d frame settings; %0d updates compared.",
			items_sent, PHASES + 2, checked);
		if (fail_count == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
